// ----- sv/dhoat_pkg.sv -----
// Shared types and constants for the double hash open address table.
package dhoat_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int SIZE_W = 11;
	localparam int LIVE_W = 11;
	localparam int DCNT_W = 6;
	localparam logic [SIZE_W-1:0] DEFAULT_SIZE = 11'd1021;
	localparam int MIN_SIZE = 3;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_GET = 2'd2;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_UPDATED = 3'd1;
	localparam logic [2:0] ST_REMOVED = 3'd2;
	localparam logic [2:0] ST_FOUND = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [VAL_W-1:0]  value_out;
		logic [LIVE_W-1:0] live_count;
	} rsp_t;

	typedef struct packed {
		logic             active;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic seed;
		logic rd;
		logic chk;
		logic clr;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic probe_end;
	} sts_t;

endpackage

// ----- sv/dhoat_div.sv -----
// Bit-serial remainder unit: key mod size and key mod (size - 2) side by side.
module dhoat_div #(
	parameter int SW = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       step,
	input  logic [dhoat_pkg::KEY_W-1:0] dividend,
	input  logic [SW-1:0]              d1,
	input  logic [SW-1:0]              d2,
	output logic [SW-1:0]              rem1,
	output logic [SW-1:0]              rem2,
	output logic                       done
);

	logic [dhoat_pkg::KEY_W-1:0]  kshift_q;
	logic [SW-1:0]                r1_q;
	logic [SW-1:0]                r2_q;
	logic [dhoat_pkg::DCNT_W-1:0] cnt_q;
	logic [SW:0]                  t1;
	logic [SW:0]                  t2;
	logic [SW:0]                  n1;
	logic [SW:0]                  n2;

	// Shift in one dividend bit, subtract where the divisor fits
	always_comb begin
		t1 = {r1_q, kshift_q[dhoat_pkg::KEY_W-1]};
		t2 = {r2_q, kshift_q[dhoat_pkg::KEY_W-1]};
		n1 = (t1 >= {1'b0, d1}) ? t1 - {1'b0, d1} : t1;
		n2 = (t2 >= {1'b0, d2}) ? t2 - {1'b0, d2} : t2;
	end

	// Count steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Hold partial remainders
	always_ff @(posedge clk) begin
		if (load) begin
			kshift_q <= dividend;
			r1_q     <= '0;
			r2_q     <= '0;
		end else if (step) begin
			kshift_q <= kshift_q << 1;
			r1_q     <= n1[SW-1:0];
			r2_q     <= n2[SW-1:0];
		end
	end

	assign rem1 = r1_q;
	assign rem2 = r2_q;
	assign done = (cnt_q == dhoat_pkg::DCNT_W'(dhoat_pkg::KEY_W));

endmodule

// ----- sv/dhoat_dp.sv -----
// Datapath: size register, remainder unit, slot memory, probe walk and result register.
module dhoat_dp #(
	parameter int CAPACITY = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dhoat_pkg::SIZE_W-1:0] cfg_wdata,
	input  dhoat_pkg::req_t              req,
	input  dhoat_pkg::cmd_t              cmd,
	output dhoat_pkg::sts_t              sts,
	output dhoat_pkg::rsp_t              rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int SW = $clog2(CAPACITY + 1);

	logic [dhoat_pkg::SIZE_W-1:0] size_q;
	logic [31:0]                  sz32;
	logic [31:0]                  s32;
	logic [SW-1:0]                s;
	logic [SW-1:0]                rem1;
	logic [SW-1:0]                rem2;
	logic                         div_done;
	dhoat_pkg::req_t              req_q;
	logic [AW-1:0]                idx_q;
	logic [SW-1:0]                pcnt_q;
	logic [SW-1:0]                live_q;
	logic [AW-1:0]                clr_q;
	dhoat_pkg::entry_t            mem [CAPACITY];
	dhoat_pkg::entry_t            rdata_q;
	logic [SW:0]                  nsum;
	logic [SW:0]                  nidx;
	logic                         km;
	logic                         vz;
	logic                         last;
	logic                         hit_end;
	logic                         do_wr;
	logic                         inc;
	logic                         dec;
	dhoat_pkg::entry_t            wentry;
	logic [2:0]                   res_status;
	logic [dhoat_pkg::VAL_W-1:0]  res_value;
	logic [2:0]                   res_status_q;
	logic [dhoat_pkg::VAL_W-1:0]  res_value_q;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	dhoat_pkg::entry_t            wr_data;
	dhoat_pkg::rsp_t              rsp_q;

	// Size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= dhoat_pkg::DEFAULT_SIZE;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// Clamp the size into range
	always_comb begin
		sz32 = 32'(size_q);
		if (sz32 < 32'(dhoat_pkg::MIN_SIZE)) begin
			s32 = 32'(dhoat_pkg::MIN_SIZE);
		end else if (sz32 > 32'(CAPACITY)) begin
			s32 = 32'(CAPACITY);
		end else begin
			s32 = sz32;
		end
		s = SW'(s32);
	end

	dhoat_div #(
		.SW(SW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (cmd.load),
		.step    (cmd.div_step),
		.dividend(req.key),
		.d1      (s),
		.d2      (s - SW'(2)),
		.rem1    (rem1),
		.rem2    (rem2),
		.done    (div_done)
	);

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// Next probe slot: idx + step stays below twice the size
	always_comb begin
		nsum = (SW+1)'(idx_q) + (SW+1)'(rem2) + (SW+1)'(1);
		nidx = (nsum >= (SW+1)'(s)) ? nsum - (SW+1)'(s) : nsum;
	end

	// Probe index and probe count
	always_ff @(posedge clk) begin
		if (cmd.seed) begin
			idx_q  <= rem1[AW-1:0];
			pcnt_q <= '0;
		end else if (cmd.chk && !hit_end) begin
			idx_q  <= nidx[AW-1:0];
			pcnt_q <= pcnt_q + 1'b1;
		end
	end

	// Judge the slot just read
	always_comb begin
		km         = (rdata_q.key == req_q.key);
		vz         = (rdata_q.value == '0);
		last       = (pcnt_q == s - SW'(1));
		hit_end    = 1'b0;
		do_wr      = 1'b0;
		inc        = 1'b0;
		dec        = 1'b0;
		wentry     = rdata_q;
		res_status = dhoat_pkg::ST_NOT_FOUND;
		res_value  = '0;
		priority if (req_q.opcode == dhoat_pkg::OP_INSERT) begin
			if (!rdata_q.active || km) begin
				hit_end    = 1'b1;
				do_wr      = 1'b1;
				wentry     = '{active: 1'b1, key: req_q.key, value: req_q.value_in};
				inc        = !rdata_q.active;
				res_status = rdata_q.active ? dhoat_pkg::ST_UPDATED : dhoat_pkg::ST_INSERTED;
			end else if (last) begin
				hit_end    = 1'b1;
				res_status = dhoat_pkg::ST_FULL;
			end
		end else if (req_q.opcode == dhoat_pkg::OP_REMOVE) begin
			if (vz) begin
				hit_end = 1'b1;
			end else if (km && rdata_q.active) begin
				hit_end       = 1'b1;
				do_wr         = 1'b1;
				wentry.active = 1'b0;
				dec           = (live_q != '0);
				res_status    = dhoat_pkg::ST_REMOVED;
				res_value     = rdata_q.value;
			end else if (km || last) begin
				hit_end = 1'b1;
			end
		end else if (req_q.opcode == dhoat_pkg::OP_GET && live_q != '0) begin
			if (km && rdata_q.active) begin
				hit_end    = 1'b1;
				res_status = dhoat_pkg::ST_FOUND;
				res_value  = rdata_q.value;
			end else if (km || vz || last) begin
				hit_end = 1'b1;
			end
		end else begin
			hit_end = 1'b1;
		end
	end

	// Active entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (cmd.chk && inc) begin
			live_q <= live_q + 1'b1;
		end else if (cmd.chk && dec) begin
			live_q <= live_q - 1'b1;
		end
	end

	// Clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Pick the memory write
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = wentry;
		if (cmd.clr) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (cmd.chk && do_wr) begin
			wr_en = 1'b1;
		end
	end

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx_q];
		end
	end

	// Hold the outcome of the probe walk
	always_ff @(posedge clk) begin
		if (cmd.chk && hit_end) begin
			res_status_q <= res_status;
			res_value_q  <= res_value;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.status     <= res_status_q;
			rsp_q.value_out  <= res_value_q;
			rsp_q.live_count <= dhoat_pkg::LIVE_W'(live_q);
		end
	end

	assign rsp           = rsp_q;
	assign sts.clr_done  = (clr_q == AW'(CAPACITY - 1));
	assign sts.div_done  = div_done;
	assign sts.probe_end = hit_end;

endmodule

// ----- sv/dhoat_ctrl.sv -----
// Controller state machine: clear sweep, remainder run, probe walk and result handoff.
module dhoat_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  dhoat_pkg::sts_t sts,
	output dhoat_pkg::cmd_t cmd
);

	dhoat_pkg::state_t state_q;
	dhoat_pkg::state_t state_d;
	logic              rsp_valid_q;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhoat_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dhoat_pkg::S_CLEAR: if (sts.clr_done) state_d = dhoat_pkg::S_IDLE;
			dhoat_pkg::S_IDLE:  if (req_valid) state_d = dhoat_pkg::S_DIV;
			dhoat_pkg::S_DIV:   if (sts.div_done) state_d = dhoat_pkg::S_READ;
			dhoat_pkg::S_READ:  state_d = dhoat_pkg::S_CHECK;
			dhoat_pkg::S_CHECK: state_d = sts.probe_end ? dhoat_pkg::S_DONE : dhoat_pkg::S_READ;
			dhoat_pkg::S_DONE:  if (!rsp_valid_q || rsp_ready) state_d = dhoat_pkg::S_IDLE;
			default:            state_d = dhoat_pkg::S_CLEAR;
		endcase
	end

	// Commands
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			dhoat_pkg::S_CLEAR: cmd.clr = 1'b1;
			dhoat_pkg::S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			dhoat_pkg::S_DIV: begin
				cmd.div_step = !sts.div_done;
				cmd.seed     = sts.div_done;
			end
			dhoat_pkg::S_READ:  cmd.rd = 1'b1;
			dhoat_pkg::S_CHECK: cmd.chk = 1'b1;
			dhoat_pkg::S_DONE:  cmd.finish = !rsp_valid_q || rsp_ready;
			default:            cmd = '0;
		endcase
	end

	// Result valid: set on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ----- sv/double_hash_open_address_table_unit.sv -----
// Top level of the double hash open address table.
//
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  request | req_valid, req_ready, req      | in
//  result  | rsp_valid, rsp_ready, rsp      | out
//  config  | cfg_we, cfg_wdata (table size) | in
//
// A request first runs the bit-serial remainder unit, then a read state and a check state
// per slot probed through the registered read port of the slot memory.
// After reset a clearing pass zeroes the memory, one slot a cycle, before the first
// request is taken; size writes are taken throughout.
// A new request is taken while the previous result waits in the output register.
module double_hash_open_address_table_unit #(
	parameter int CAPACITY = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  dhoat_pkg::req_t              req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output dhoat_pkg::rsp_t              rsp,
	input  logic                         cfg_we,
	input  logic [dhoat_pkg::SIZE_W-1:0] cfg_wdata
);

	dhoat_pkg::cmd_t cmd;
	dhoat_pkg::sts_t sts;

	dhoat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dhoat_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

`ifndef NO_ASSERTIONS
	// One request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// Status codes stay in range
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= dhoat_pkg::ST_FULL)
		else $error("result status out of range");

	// A result never reports more entries than slots
	a_live_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.live_count) <= 32'(CAPACITY))
		else $error("live count above capacity");
`endif

endmodule
